[hdl/cotrk_pkg.sv]
package cotrk_pkg;

  // Nanoseconds per second
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // Stream payload widths
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 3;

  // Reciprocals of 5^9 for the stamp conversion (10^9 = 2^9 * 5^9):
  //   seconds  = floor((t >> 9) * RECIP_SEC / 2^76),   t >> 9 below 2^55
  //   fraction = floor(rem * RECIP_FRAC / 2^51),        rem below 10^9
  // Both are ceil(2^k / 5^9); the rounding error stays under one step.
  localparam logic [55:0] RECIP_SEC  = 56'd38685626227668134;
  localparam logic [53:0] RECIP_FRAC = 54'd9671406556917034;

  // Front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_REPLY = 1'b0,
    OP_STAMP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_OUT_OF_ORDER = 2'd1,
    ST_NOT_BETTER   = 2'd2,
    ST_STAMP        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CMP,
    BK_MULS,
    BK_SUM,
    BK_ADD,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    op_t         op;
    logic        out_of_order;
    logic [62:0] rtt;
    logic [62:0] mid;
    logic [63:0] remote;
    logic [62:0] loc_ns;
  } entry_t;

  typedef struct packed {
    logic [63:0] ntp_stamp;
    logic [63:0] offset;
    logic        offset_valid;
    status_t     status;
  } result_t;

endpackage

[hdl/cotrk_front.sv]
module cotrk_front
  import cotrk_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  q_full,
  output logic                  push,
  output entry_t                push_entry
);

  logic [62:0] send_ns;
  logic [62:0] recv_ns;
  logic [63:0] diff;
  logic [63:0] sum;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  assign send_ns = in_tdata[62:0];
  assign recv_ns = in_tdata[189:127];

  // borrow out of the difference flags receive before send
  assign diff = {1'b0, recv_ns} - {1'b0, send_ns};
  assign sum  = {1'b0, send_ns} + {1'b0, recv_ns};

  always_comb begin
    push_entry.op           = op_t'(in_tuser[0]);
    push_entry.out_of_order = diff[63];
    push_entry.rtt          = diff[62:0];
    push_entry.mid          = sum[63:1];
    push_entry.remote       = in_tdata[126:63];
    push_entry.loc_ns       = in_tdata[252:190];
  end

endmodule

[hdl/cotrk_queue.sv]
module cotrk_queue
  import cotrk_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t head
);

  entry_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[hdl/cotrk_div.sv]
module cotrk_div
  import cotrk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] t_ns,
  output logic        done,
  output logic [63:0] quot
);

  // six registered steps from start: input capture, partial products, two
  // partial sums, seconds, remainder, fraction products; done follows the last
  logic [63:0]  t_r;
  logic [5:0]   vld_r;
  logic [63:0]  p00_r;     // u[31:0]  * RECIP_SEC[31:0]
  logic [55:0]  p01_r;     // u[31:0]  * RECIP_SEC[55:32]
  logic [54:0]  p10_r;     // u[54:32] * RECIP_SEC[31:0]
  logic [46:0]  p11_r;     // u[54:32] * RECIP_SEC[55:32]
  logic [87:0]  lo_acc_r;
  logic [78:0]  hi_acc_r;
  logic [31:0]  sec_r;
  logic [29:0]  rem_r;
  logic [61:0]  f_lo_r;
  logic [51:0]  f_hi_r;

  logic [54:0]  u;
  logic [110:0] sec_full;
  logic [31:0]  sec_ns;
  logic [31:0]  rem_diff;
  logic [83:0]  frac_full;

  assign u         = t_r[63:9];
  assign sec_full  = 111'(lo_acc_r) + {hi_acc_r, 32'd0};
  // remainder is below 2^30, so the low 32 bits of seconds * 10^9 suffice
  assign sec_ns    = sec_r * 32'(NS_PER_SEC);
  assign rem_diff  = t_r[31:0] - sec_ns;
  assign frac_full = 84'(f_lo_r) + {f_hi_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) t_r <= t_ns;
    if (vld_r[0]) begin
      p00_r <= 64'(u[31:0]) * 64'(RECIP_SEC[31:0]);
      p01_r <= 56'(u[31:0]) * 56'(RECIP_SEC[55:32]);
      p10_r <= 55'(u[54:32]) * 55'(RECIP_SEC[31:0]);
      p11_r <= 47'(u[54:32]) * 47'(RECIP_SEC[55:32]);
    end
    if (vld_r[1]) begin
      lo_acc_r <= 88'(p00_r) + {p01_r, 32'd0};
      hi_acc_r <= 79'(p10_r) + {p11_r, 32'd0};
    end
    // seconds wrap modulo 2^32 in the stamp
    if (vld_r[2]) sec_r <= sec_full[107:76];
    if (vld_r[3]) rem_r <= rem_diff[29:0];
    if (vld_r[4]) begin
      f_lo_r <= 62'(rem_r) * 62'(RECIP_FRAC[31:0]);
      f_hi_r <= 52'(rem_r) * 52'(RECIP_FRAC[53:32]);
    end
  end

  assign done = vld_r[5];
  assign quot = {sec_r, frac_full[82:51]};

endmodule

[hdl/cotrk_back.sv]
module cotrk_back
  import cotrk_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  entry_t  head,
  output logic    pop,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_res
);

  bk_state_t   state_r, state_nxt;
  entry_t      wk_r;
  status_t     status_r, status_nxt;
  logic [61:0] prod_r;
  logic [29:0] frac_ns_r;
  logic [63:0] offset_r, offset_nxt;
  logic [63:0] best_r;
  logic        have_r;
  logic [63:0] stamp_r;
  result_t     out_r;
  logic        out_valid_r;

  logic        take;
  logic        upd;
  logic        load_out;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_quot;
  logic        out_free;
  logic [31:0] mul_a;
  logic [61:0] mul_p;
  logic [64:0] loc_sum;
  logic [63:0] t_ns;

  // shared multiplier: fraction in BK_CMP, seconds in BK_MULS
  assign mul_a = (state_r == BK_CMP) ? wk_r.remote[31:0] : wk_r.remote[63:32];
  assign mul_p = 62'(mul_a) * 62'(NS_PER_SEC);

  assign offset_nxt = 64'(prod_r) + 64'(frac_ns_r) - {1'b0, wk_r.mid};

  // local + offset in 65 bits, negative clamps to zero
  assign loc_sum = {2'b00, wk_r.loc_ns} + {offset_r[63], offset_r};
  assign t_ns    = loc_sum[64] ? '0 : loc_sum[63:0];

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    take       = 1'b0;
    upd        = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) take = 1'b1;
      end
      BK_CMP: begin
        if (have_r && ({1'b0, wk_r.rtt} >= best_r)) begin
          status_nxt = ST_NOT_BETTER;
          state_nxt  = BK_OUT;
        end else begin
          state_nxt = BK_MULS;
        end
      end
      BK_MULS: state_nxt = BK_SUM;
      BK_SUM: begin
        upd        = 1'b1;
        status_nxt = ST_ACCEPTED;
        state_nxt  = BK_OUT;
      end
      BK_ADD: begin
        div_start = 1'b1;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (div_done) state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
          if (q_valid) take = 1'b1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (take) begin
      case (head.op)
        OP_STAMP: begin
          status_nxt = ST_STAMP;
          state_nxt  = BK_ADD;
        end
        default: begin
          if (head.out_of_order) begin
            status_nxt = ST_OUT_OF_ORDER;
            state_nxt  = BK_OUT;
          end else begin
            state_nxt = BK_CMP;
          end
        end
      endcase
    end
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      status_r    <= ST_ACCEPTED;
      offset_r    <= '0;
      best_r      <= '1;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (upd) begin
        offset_r <= offset_nxt;
        best_r   <= {1'b0, wk_r.rtt};
        have_r   <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) wk_r <= head;
    if (state_r == BK_CMP || state_r == BK_MULS) prod_r <= mul_p;
    if (state_r == BK_MULS) frac_ns_r <= prod_r[61:32];
    if (state_r == BK_DIV && div_done) stamp_r <= div_quot;
    if (load_out) begin
      out_r.ntp_stamp    <= (status_r == ST_STAMP) ? stamp_r : '0;
      out_r.offset       <= offset_r;
      out_r.offset_valid <= have_r;
      out_r.status       <= status_r;
    end
  end

  cotrk_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .t_ns  (t_ns),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_res    = out_r;

  a_accept_has_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_ACCEPTED) |-> out_r.offset_valid)
    else $error("accepted reply shown without a valid offset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r)
    else $error("offset valid dropped");

  a_sum_is_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SUM) |-> (wk_r.op == OP_REPLY) && !wk_r.out_of_order)
    else $error("offset update from a non-reply item");

endmodule

[hdl/clock_offset_min_rtt_tracker.sv]
// Clock offset tracker with lowest-round-trip selection. Each timing-reply
// item (in_tuser = 0) carries local send time, a remote 32.32 NTP stamp and
// local receive time; it replaces the held offset (remote ns minus local
// midpoint) when it is in order and either no offset exists yet or its round
// trip is strictly below the best so far. A stamp item (in_tuser = 1) turns
// local ns plus the offset, clamped at zero, into a 32.32 NTP stamp with the
// seconds wrapping modulo 2^32. Every item gives exactly one result. A front
// stage classifies items (order check, round trip, midpoint) into a two-entry
// queue; the back end then works them one at a time, taking the next item in
// the cycle the result is handed on. A reply out of order goes straight to
// the output; one that is not better stops after the compare; an accepted
// reply is compared, uses one 32x30 multiplier twice, then forms the offset
// sum; a stamp adds the offset, then waits on the six-step reciprocal multiply
// that splits the sum into seconds and remainder and scales the remainder to
// the fraction. An idle back end first picks up an item. A finished result
// waits in the output register while the next item is already being worked.
module clock_offset_min_rtt_tracker
  import cotrk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [62:0] send_time_ns, [126:63] remote_stamp, [189:127] receive_time_ns,
  // [252:190] local_time_ns, [255:253] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [63:0] ntp_stamp, [127:64] current_offset_ns
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] offset_valid, [2:1] status
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic    push;
  entry_t  push_entry;
  logic    q_full;
  logic    q_valid;
  logic    pop;
  entry_t  head;
  result_t out_res;

  // front: classify and enqueue
  cotrk_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue between front and back
  cotrk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  // back: round-trip compare, offset update, stamp conversion, output register
  cotrk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.offset, out_res.ntp_stamp};
  assign out_tuser = {out_res.status, out_res.offset_valid};

endmodule
